// ===== rtl/cst_pkg.sv =====
package cst_pkg;

   // Field widths of the command and response beats.
   localparam int CMD_W     = 4;
   localparam int ADDR_W    = 14;
   localparam int MODE_W    = 2;
   localparam int NODE_W    = 16;
   localparam int PIDX_W    = 8;
   localparam int KIND_W    = 4;
   localparam int SESS_W    = 8;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int KEY_W     = ADDR_W + 1;

   localparam int SESSION_COUNT_DEFAULT = 255;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TRACK_OFF   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_TRACK_ON    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_ESTOP       = 4'd2;
   localparam logic [CMD_W-1:0] CMD_STATUS      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_NODE_QUERY  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_REQ_SESSION = 4'd5;
   localparam logic [CMD_W-1:0] CMD_GET_SESSION = 4'd6;
   localparam logic [CMD_W-1:0] CMD_READ_PARAM  = 4'd7;

   // Get-session modes.
   localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEAL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SHARE   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

   // Response kinds.
   localparam logic [KIND_W-1:0] KIND_TRACK_OFF = 4'd0;
   localparam logic [KIND_W-1:0] KIND_TRACK_ON  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_ESTOP     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_PRESENCE  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_PARAM     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_INVALID   = 4'd6;
   localparam logic [KIND_W-1:0] KIND_TAKEN     = 4'd7;
   localparam logic [KIND_W-1:0] KIND_FULL      = 4'd8;
   localparam logic [KIND_W-1:0] KIND_CANCEL    = 4'd9;
   localparam logic [KIND_W-1:0] KIND_REPORT    = 4'd10;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_NUMBER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUS_ON      = 1'b1;

   // Node parameter table.
   localparam int PARAM_COUNT = 21;
   localparam logic [BYTE_W-1:0] PARAM_TABLE [PARAM_COUNT] = '{
      8'd20, 8'd165, 8'd102, 8'd83, 8'd255, 8'd10, 8'd216, 8'd4, 8'd14, 8'd3, 8'd1,
      8'd0, 8'd8, 8'd0, 8'd0, 8'd196, 8'd26, 8'd0, 8'd0, 8'd1, 8'd12
   };

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SESS_W-1:0] session;
      logic [ADDR_W-1:0] address;
      logic              long_address;
      logic [PIDX_W-1:0] param_number;
      logic [BYTE_W-1:0] data_byte;
      logic              track_on;
      logic              bus_on;
      logic              estop;
      logic              last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_run;
      logic decide;
      logic advance;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic res_none;
      logic res_two;
   } ctl_status_type;

endpackage

// ===== rtl/cst_ctrl.sv =====
module cst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  cst_pkg::ctl_status_type status,
   output cst_pkg::ctl_cmd_type    command
);
   import cst_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_RESP1  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP1);

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      command   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               command.load = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.need_scan) begin
               command.scan_start = 1'b1;
               state_in           = ST_SCAN;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_SCAN: begin
            command.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            command.decide = 1'b1;
            second_in      = 1'b0;
            state_in       = status.res_none ? ST_IDLE : ST_RESP1;
         end
         ST_RESP1: begin
            // The second beat of a steal follows the first from the same register.
            if (rsp_ready) begin
               if (status.res_two && !second_ff) begin
                  command.advance = 1'b1;
                  second_in       = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

// ===== rtl/cst_datapath.sv =====
module cst_datapath #(
   parameter int SESSION_COUNT = cst_pkg::SESSION_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cst_pkg::CMD_W-1:0]     req_cmd,
   input  logic [cst_pkg::ADDR_W-1:0]    req_address,
   input  logic                          req_long_address,
   input  logic [cst_pkg::MODE_W-1:0]    req_mode,
   input  logic [cst_pkg::NODE_W-1:0]    req_target_node,
   input  logic [cst_pkg::PIDX_W-1:0]    req_param_index,
   input  logic                          csr_write,
   input  logic [cst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cst_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  cst_pkg::ctl_cmd_type          command,
   output cst_pkg::ctl_status_type       status,
   output cst_pkg::rsp_type              rsp
);
   import cst_pkg::*;

   localparam int AW = (SESSION_COUNT > 1) ? $clog2(SESSION_COUNT) : 1;
   localparam int CW = $clog2(SESSION_COUNT + 1);
   localparam logic [CW-1:0] SCAN_END = CW'(SESSION_COUNT);

   // Latched command beat.
   logic [CMD_W-1:0]  cmd_ff;
   logic [ADDR_W-1:0] address_ff;
   logic              long_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [NODE_W-1:0] target_ff;
   logic [PIDX_W-1:0] pidx_ff;

   // Configuration and station flags.
   logic [NODE_W-1:0] node_number_ff;
   logic              bus_on_ff;
   logic              track_on_ff, track_on_in;
   logic              estop_ff, estop_in;

   // Session table: valid bits in flops, address and long flag in memory.
   logic [SESSION_COUNT-1:0] slot_valid_ff, slot_valid_in;
   logic [KEY_W-1:0]         slot_mem [SESSION_COUNT];
   logic [KEY_W-1:0]         rd_ff;
   logic                     mem_we;

   // Scan pipeline.
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          issue;
   logic          chk_vld_ff;
   logic          chk_slot_ff;
   logic [AW-1:0] chk_idx_ff;
   logic          found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;

   // Result formation.
   rsp_type          out_ff, res2_ff, res1, res2;
   logic             res_two_ff;
   logic [1:0]       res_count;
   logic [MODE_W-1:0] mode_eff;
   logic [KEY_W-1:0] key;
   logic             alloc, release_old;
   logic [SESS_W-1:0] found_sess, free_sess;

   assign key        = {long_ff, address_ff};
   assign found_sess = SESS_W'(found_idx_ff) + SESS_W'(1);
   assign free_sess  = SESS_W'(free_idx_ff) + SESS_W'(1);
   assign mode_eff   = (cmd_ff == CMD_REQ_SESSION) ? MODE_REQUEST : mode_ff;

   assign status.need_scan = ((cmd_ff == CMD_REQ_SESSION) || (cmd_ff == CMD_GET_SESSION))
                             && (mode_eff != MODE_INVALID);
   assign status.scan_done = (scan_idx_ff == SCAN_END) && !chk_vld_ff;
   assign status.res_none  = (res_count == 2'd0);
   assign status.res_two   = res_two_ff;
   assign rsp              = out_ff;

   always_ff @(posedge clock) begin
      if (command.load) begin
         cmd_ff     <= req_cmd;
         address_ff <= req_address;
         long_ff    <= req_long_address;
         mode_ff    <= req_mode;
         target_ff  <= req_target_node;
         pidx_ff    <= req_param_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_number_ff <= '0;
         bus_on_ff      <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NODE_NUMBER: node_number_ff <= csr_wdata;
            CSR_BUS_ON:      bus_on_ff      <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // Scan: issue one read per cycle and compare it in the cycle after, from the registered read.
   always_comb begin
      issue        = command.scan_run && (scan_idx_ff != SCAN_END);
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      if (command.scan_start) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
         free_in     = 1'b0;
      end else begin
         if (issue) begin
            scan_idx_in = scan_idx_ff + CW'(1);
         end
         if (chk_vld_ff) begin
            if (chk_slot_ff && (rd_ff == key) && !found_ff) begin
               found_in     = 1'b1;
               found_idx_in = chk_idx_ff;
            end
            if (!chk_slot_ff && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= SCAN_END;
         chk_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
      end else begin
         scan_idx_ff <= scan_idx_in;
         chk_vld_ff  <= issue;
         found_ff    <= found_in;
         free_ff     <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff   <= scan_idx_ff[AW-1:0];
      chk_slot_ff  <= slot_valid_ff[scan_idx_ff[AW-1:0]];
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[free_idx_ff] <= key;
      end
      rd_ff <= slot_mem[scan_idx_ff[AW-1:0]];
   end

   // Decision: results and state updates, applied when the controller says so.
   always_comb begin
      res1        = '0;
      res2        = '0;
      res_count   = 2'd0;
      track_on_in = track_on_ff;
      estop_in    = estop_ff;
      alloc       = 1'b0;
      release_old = 1'b0;
      case (cmd_ff)
         CMD_TRACK_OFF: begin
            res1.kind   = KIND_TRACK_OFF;
            res_count   = 2'd1;
            track_on_in = 1'b0;
         end
         CMD_TRACK_ON: begin
            res1.kind   = KIND_TRACK_ON;
            res_count   = 2'd1;
            track_on_in = 1'b1;
         end
         CMD_ESTOP: begin
            res1.kind = KIND_ESTOP;
            res_count = 2'd1;
            estop_in  = 1'b1;
         end
         CMD_STATUS: begin
            res1.kind     = KIND_STATUS;
            res1.track_on = track_on_ff;
            res1.bus_on   = bus_on_ff;
            res1.estop    = estop_ff;
            res_count     = 2'd1;
         end
         CMD_NODE_QUERY: begin
            res1.kind = KIND_PRESENCE;
            res_count = 2'd1;
         end
         CMD_REQ_SESSION, CMD_GET_SESSION: begin
            res1.address      = address_ff;
            res1.long_address = long_ff;
            if (mode_eff == MODE_INVALID) begin
               res1.kind = KIND_INVALID;
               res_count = 2'd1;
            end else if (found_ff) begin
               if (mode_eff == MODE_REQUEST) begin
                  res1.kind = KIND_TAKEN;
                  res_count = 2'd1;
               end else if (mode_eff == MODE_SHARE) begin
                  res1.kind    = KIND_REPORT;
                  res1.session = found_sess;
                  res_count    = 2'd1;
               end else if (free_ff) begin
                  // Steal: cancel the old session, report the new one.
                  res1              = '0;
                  res1.kind         = KIND_CANCEL;
                  res1.session      = found_sess;
                  res2.kind         = KIND_REPORT;
                  res2.session      = free_sess;
                  res2.address      = address_ff;
                  res2.long_address = long_ff;
                  res_count         = 2'd2;
                  alloc             = 1'b1;
                  release_old       = 1'b1;
               end else begin
                  res1.kind = KIND_FULL;
                  res_count = 2'd1;
               end
            end else if (mode_eff == MODE_SHARE) begin
               res1      = '0;
               res_count = 2'd0;
            end else if (free_ff) begin
               res1.kind    = KIND_REPORT;
               res1.session = free_sess;
               res_count    = 2'd1;
               alloc        = 1'b1;
            end else begin
               res1.kind = KIND_FULL;
               res_count = 2'd1;
            end
         end
         CMD_READ_PARAM: begin
            if ((target_ff == node_number_ff) && (pidx_ff < PIDX_W'(PARAM_COUNT))) begin
               res1.kind         = KIND_PARAM;
               res1.param_number = pidx_ff;
               res1.data_byte    = PARAM_TABLE[pidx_ff[4:0]];
               res_count         = 2'd1;
            end
         end
         default: begin
            res_count = 2'd0;
         end
      endcase
      if (res_count == 2'd2) begin
         res2.last = 1'b1;
      end else begin
         res1.last = 1'b1;
      end
   end

   assign mem_we = command.decide && alloc;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (command.decide && alloc) begin
         slot_valid_in[free_idx_ff] = 1'b1;
      end
      if (command.decide && release_old) begin
         slot_valid_in[found_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_on_ff   <= 1'b0;
         estop_ff      <= 1'b0;
         slot_valid_ff <= '0;
         res_two_ff    <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         if (command.decide) begin
            track_on_ff <= track_on_in;
            estop_ff    <= estop_in;
            res_two_ff  <= (res_count == 2'd2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (command.decide) begin
         out_ff  <= res1;
         res2_ff <= res2;
      end else if (command.advance) begin
         out_ff <= res2_ff;
      end
   end

endmodule

// ===== rtl/command_station_session_table.sv =====
// A session command with a valid mode scans the table before the decision; any other command goes
// from the check straight to the decision. One command at a time: a new one is accepted only after
// the last response beat is taken, or straight after a decision with nothing to answer. A steal
// answers with a second beat, and receiver stalls hold the block in its response state.
// Reset (synchronous, active high) clears the flags, the session valid bits and the controller;
// node_number resets to 0 and bus_on to 1. No clearing pass is needed.
module command_station_session_table #(
   parameter int SESSION_COUNT = cst_pkg::SESSION_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cst_pkg::CMD_W-1:0]     req_cmd,
   input  logic [cst_pkg::ADDR_W-1:0]    req_address,
   input  logic                          req_long_address,
   input  logic [cst_pkg::MODE_W-1:0]    req_mode,
   input  logic [cst_pkg::NODE_W-1:0]    req_target_node,
   input  logic [cst_pkg::PIDX_W-1:0]    req_param_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cst_pkg::KIND_W-1:0]    rsp_kind,
   output logic [cst_pkg::SESS_W-1:0]    rsp_session,
   output logic [cst_pkg::ADDR_W-1:0]    rsp_address_res,
   output logic                          rsp_long_address_res,
   output logic [cst_pkg::PIDX_W-1:0]    rsp_param_number,
   output logic [cst_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic                          rsp_track_on_flag,
   output logic                          rsp_bus_on_flag,
   output logic                          rsp_estop_flag,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic [cst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cst_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import cst_pkg::*;

   // The controller sequences each command: latch the beat, optionally sweep the
   // session table one slot per cycle, decide, then present up to two response beats, or none.
   // The datapath holds the flags, the configuration, the table and the response register.
   ctl_cmd_type    command;
   ctl_status_type status;
   rsp_type        rsp;

   cst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .command   (command)
   );

   // The sweep looks for the matching session and the lowest free slot in one pass,
   // so a steal sees its own old slot as taken and reports full on a full table.
   cst_datapath #(
      .SESSION_COUNT (SESSION_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_address      (req_address),
      .req_long_address (req_long_address),
      .req_mode         (req_mode),
      .req_target_node  (req_target_node),
      .req_param_index  (req_param_index),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .command          (command),
      .status           (status),
      .rsp              (rsp)
   );

   // Response beat fields come straight from the response register.
   assign rsp_kind             = rsp.kind;
   assign rsp_session          = rsp.session;
   assign rsp_address_res      = rsp.address;
   assign rsp_long_address_res = rsp.long_address;
   assign rsp_param_number     = rsp.param_number;
   assign rsp_data_byte        = rsp.data_byte;
   assign rsp_track_on_flag    = rsp.track_on;
   assign rsp_bus_on_flag      = rsp.bus_on;
   assign rsp_estop_flag       = rsp.estop;
   assign rsp_last             = rsp.last;

endmodule
